### rtl/core/iba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package iba_pkg;

    localparam int BLOCK_W        = 7;
    localparam int STATUS_W       = 3;
    localparam int NUM_BLOCKS_DEF = 128;

    typedef enum logic [STATUS_W-1:0] {
        ST_PENDING   = 3'd0,
        ST_ALLOCATED = 3'd1,
        ST_IDX_BUSY  = 3'd2,
        ST_CONFLICT  = 3'd3,
        ST_NO_FILE   = 3'd4
    } t_status;

endpackage

`default_nettype wire

### rtl/core/iba_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface iba_in_if;
    import iba_pkg::*;

    logic               valid;
    logic               ready;
    logic               command;
    logic [BLOCK_W-1:0] block_number;
    logic               last_item;

    modport source (output valid, output command, output block_number, output last_item,
                    input ready);
    modport sink   (input valid, input command, input block_number, input last_item,
                    output ready);
endinterface

interface iba_out_if;
    import iba_pkg::*;

    logic               valid;
    logic               ready;
    t_status            status;
    logic [BLOCK_W-1:0] index_block;

    modport source (output valid, output status, output index_block, input ready);
    modport sink   (input valid, input status, input index_block, output ready);
endinterface

`default_nettype wire

### rtl/core/indexed_block_allocator.sv
// Allocation bitmap for an indexed file store, one file at a time, all or nothing.
// Requests arrive on i_in (command, block_number, last_item); every request gives
// exactly one result transfer on o_out (status, index_block), in request order.
// After reset the block sweeps the bitmap clear, one block a cycle, and i_in is
// not ready until the sweep ends; no request is taken during the sweep.
// A request is looked up in the bitmap in the cycle after its transfer; its result
// then passes from S_LOOKUP (through S_WALK on a commit) to S_DONE, which writes
// it to the output register once that is free. A commit (the last item of an
// accepted file) marks the index block and then walks the pending list, one
// entry a cycle through the list memory, marking each listed block. The bitmap
// write port is shared by the sweep, the lookup and the walk.
// The block takes the next request while a result waits in the output register;
// if the receiver stalls, the next result waits in the sequencer and i_in stays
// low until the output register is free again.
`timescale 1ns / 1ps
`default_nettype none

module indexed_block_allocator #(
    parameter int NUM_BLOCKS = iba_pkg::NUM_BLOCKS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    iba_in_if.sink     i_in,
    iba_out_if.source  o_out
);
    import iba_pkg::*;

    localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam int EW = (CW > BLOCK_W) ? CW : BLOCK_W;
    localparam logic [CW-1:0] FULL      = CW'(NUM_BLOCKS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BLOCKS - 1);
    localparam logic [EW-1:0] LIMIT     = EW'(NUM_BLOCKS);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_LOOKUP = 5'b00100,
        S_WALK   = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr, n_clr;
    logic               r_cmd, n_cmd;
    logic [BLOCK_W-1:0] r_blk, n_blk;
    logic               r_last, n_last;
    logic               r_map_rd;
    logic               r_file_open, n_file_open;
    logic               r_conflict, n_conflict;
    logic [CW-1:0]      r_count, n_count;
    logic [BLOCK_W-1:0] r_open_idx, n_open_idx;
    logic [CW-1:0]      r_walk, n_walk;
    logic [CW-1:0]      r_total, n_total;
    logic [BLOCK_W-1:0] r_pend_rd;
    logic               r_rd_vld, n_rd_vld;
    t_status            r_res_status, n_res_status;
    logic [BLOCK_W-1:0] r_res_idx, n_res_idx;
    logic               r_out_valid, n_out_valid;
    t_status            r_out_status, n_out_status;
    logic [BLOCK_W-1:0] r_out_idx, n_out_idx;

    logic               r_alloc_map [NUM_BLOCKS];
    logic [BLOCK_W-1:0] r_pending_list [NUM_BLOCKS];

    logic               in_xfer, out_xfer;
    logic [EW-1:0]      in_ext, blk_ext, open_ext, pend_ext;
    logic [AW-1:0]      in_addr, blk_addr, open_addr, pend_addr;
    logic               blk_ok;
    logic               map_we, map_wd;
    logic [AW-1:0]      map_wa;
    logic               pend_we, pend_re;
    logic               lk_conflict;
    logic [CW-1:0]      lk_count;

    assign in_xfer   = i_in.valid && i_in.ready;
    assign out_xfer  = o_out.valid && o_out.ready;
    assign in_ext    = EW'(i_in.block_number);
    assign in_addr   = in_ext[AW-1:0];
    assign blk_ext   = EW'(r_blk);
    assign blk_addr  = blk_ext[AW-1:0];
    assign blk_ok    = blk_ext < LIMIT;
    assign open_ext  = EW'(r_open_idx);
    assign open_addr = open_ext[AW-1:0];
    assign pend_ext  = EW'(r_pend_rd);
    assign pend_addr = pend_ext[AW-1:0];

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.index_block = r_out_idx;

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_cmd        = r_cmd;
        n_blk        = r_blk;
        n_last       = r_last;
        n_file_open  = r_file_open;
        n_conflict   = r_conflict;
        n_count      = r_count;
        n_open_idx   = r_open_idx;
        n_walk       = r_walk;
        n_total      = r_total;
        n_rd_vld     = r_rd_vld;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_idx    = r_out_idx;
        map_we       = 1'b0;
        map_wd       = 1'b1;
        map_wa       = '0;
        pend_we      = 1'b0;
        pend_re      = 1'b0;
        lk_conflict  = r_conflict;
        lk_count     = r_count;

        if (out_xfer) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                map_we = 1'b1;
                map_wd = 1'b0;
                map_wa = r_clr;
                n_clr  = r_clr + AW'(1);
                if (r_clr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_cmd   = i_in.command;
                    n_blk   = i_in.block_number;
                    n_last  = i_in.last_item;
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                n_state = S_DONE;
                if (!r_cmd) begin
                    // A start transfer drops any file that is still open.
                    n_file_open = 1'b0;
                    n_conflict  = 1'b0;
                    n_count     = '0;
                    n_res_idx   = r_blk;
                    if (!blk_ok || r_map_rd) begin
                        n_res_status = ST_IDX_BUSY;
                    end else begin
                        n_open_idx = r_blk;
                        if (r_last) begin
                            map_we       = 1'b1;
                            map_wa       = blk_addr;
                            n_total      = '0;
                            n_walk       = '0;
                            n_rd_vld     = 1'b0;
                            n_state      = S_WALK;
                            n_res_status = ST_ALLOCATED;
                        end else begin
                            n_file_open  = 1'b1;
                            n_res_status = ST_PENDING;
                        end
                    end
                end else if (!r_file_open) begin
                    n_res_status = ST_NO_FILE;
                    n_res_idx    = '0;
                end else begin
                    if (!blk_ok || r_count == FULL) begin
                        lk_conflict = 1'b1;
                    end else begin
                        pend_we  = 1'b1;
                        lk_count = r_count + CW'(1);
                        if (r_map_rd || r_blk == r_open_idx) begin
                            lk_conflict = 1'b1;
                        end
                    end
                    n_res_idx = r_open_idx;
                    if (!r_last) begin
                        n_conflict   = lk_conflict;
                        n_count      = lk_count;
                        n_res_status = ST_PENDING;
                    end else begin
                        n_file_open = 1'b0;
                        n_conflict  = 1'b0;
                        n_count     = '0;
                        if (lk_conflict) begin
                            n_res_status = ST_CONFLICT;
                        end else begin
                            map_we       = 1'b1;
                            map_wa       = open_addr;
                            n_total      = lk_count;
                            n_walk       = '0;
                            n_rd_vld     = 1'b0;
                            n_state      = S_WALK;
                            n_res_status = ST_ALLOCATED;
                        end
                    end
                end
            end
            S_WALK: begin
                if (r_rd_vld) begin
                    map_we = 1'b1;
                    map_wa = pend_addr;
                end
                if (r_walk != r_total) begin
                    pend_re  = 1'b1;
                    n_walk   = r_walk + CW'(1);
                    n_rd_vld = 1'b1;
                end else begin
                    n_rd_vld = 1'b0;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_idx    = r_res_idx;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_alloc_map[map_wa] <= map_wd;
        end
        if (in_xfer) begin
            r_map_rd <= r_alloc_map[in_addr];
        end
        if (pend_we) begin
            r_pending_list[r_count[AW-1:0]] <= r_blk;
        end
        if (pend_re) begin
            r_pend_rd <= r_pending_list[r_walk[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_file_open <= 1'b0;
            r_conflict  <= 1'b0;
            r_count     <= '0;
            r_open_idx  <= '0;
            r_walk      <= '0;
            r_total     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_file_open <= n_file_open;
            r_conflict  <= n_conflict;
            r_count     <= n_count;
            r_open_idx  <= n_open_idx;
            r_walk      <= n_walk;
            r_total     <= n_total;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
        r_cmd        <= n_cmd;
        r_blk        <= n_blk;
        r_last       <= n_last;
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        r_out_status <= n_out_status;
        r_out_idx    <= n_out_idx;
    end

    a_lookup_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_state == S_LOOKUP)
        else $error("accepted transfer was not looked up in the next cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("pending count above the list depth");

    a_conflict_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_conflict |-> r_file_open)
        else $error("conflict flag set with no open file");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK |-> r_walk <= r_total)
        else $error("commit walk ran past the pending list");

endmodule

`default_nettype wire

### verif/indexed_block_allocator_tb.sv
`timescale 1ns / 1ps

module indexed_block_allocator_tb;
    import iba_pkg::*;

    localparam int  NUM_BLOCKS     = NUM_BLOCKS_DEF;
    localparam bit  CMD_START      = 1'b0;
    localparam bit  CMD_DATA       = 1'b1;
    localparam int  WATCHDOG_LIMIT = 3000;
    localparam int  DRAIN_CYCLES   = 200;

    typedef struct packed {
        t_status            status;
        logic [BLOCK_W-1:0] index_block;
    } t_alloc_outcome;

    logic i_clk;
    logic i_rst_n;

    iba_in_if  req_if();
    iba_out_if res_if();

    indexed_block_allocator #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    // Predicted allocator state.
    logic [NUM_BLOCKS-1:0] taken_map;
    logic [BLOCK_W-1:0]    listed_blocks[$];
    logic [BLOCK_W-1:0]    open_index;
    bit                    file_open;
    bit                    conflict_seen;

    t_alloc_outcome outcome_q[$];
    int             error_count;
    bit             idle_en;
    int             rx_hold_cycles;
    int             idle_cycles;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic void mark_open_file();
        taken_map[open_index] = 1'b1;
        foreach (listed_blocks[k]) begin
            taken_map[listed_blocks[k]] = 1'b1;
        end
    endfunction

    function automatic t_alloc_outcome predict_allocation(bit cmd, logic [BLOCK_W-1:0] blk,
                                                          bit last);
        t_alloc_outcome res;
        if (cmd == CMD_START) begin
            file_open     = 1'b0;
            conflict_seen = 1'b0;
            listed_blocks.delete();
            res.index_block = blk;
            if (taken_map[blk]) begin
                res.status = ST_IDX_BUSY;
            end else begin
                open_index = blk;
                if (last) begin
                    mark_open_file();
                    res.status = ST_ALLOCATED;
                end else begin
                    file_open  = 1'b1;
                    res.status = ST_PENDING;
                end
            end
            return res;
        end
        if (!file_open) begin
            res.status      = ST_NO_FILE;
            res.index_block = '0;
            return res;
        end
        if (listed_blocks.size() >= NUM_BLOCKS) begin
            conflict_seen = 1'b1;
        end else begin
            listed_blocks.push_back(blk);
            if (taken_map[blk] || blk == open_index) begin
                conflict_seen = 1'b1;
            end
        end
        res.index_block = open_index;
        if (!last) begin
            res.status = ST_PENDING;
            return res;
        end
        if (conflict_seen) begin
            res.status = ST_CONFLICT;
        end else begin
            mark_open_file();
            res.status = ST_ALLOCATED;
        end
        file_open     = 1'b0;
        conflict_seen = 1'b0;
        listed_blocks.delete();
        return res;
    endfunction

    // Called and returning at a falling edge; valid is left high after the transfer.
    task automatic send_request(input bit cmd, input int blk, input bit last);
        int gap;
        gap = idle_en ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.command      <= cmd;
        req_if.block_number <= blk[BLOCK_W-1:0];
        req_if.last_item    <= last;
        do begin
            @(posedge i_clk);
        end while (!req_if.ready);
        outcome_q.push_back(predict_allocation(cmd, blk[BLOCK_W-1:0], last));
        @(negedge i_clk);
    endtask

    // Returns a random free block other than avoid, or -1 if there is none.
    function automatic int free_block(int avoid);
        int n_free;
        int pick;
        n_free = 0;
        for (int b = 0; b < NUM_BLOCKS; b++) begin
            if (!taken_map[b] && b != avoid) n_free++;
        end
        if (n_free == 0) return -1;
        pick = $urandom_range(0, n_free - 1);
        for (int b = 0; b < NUM_BLOCKS; b++) begin
            if (!taken_map[b] && b != avoid) begin
                if (pick == 0) return b;
                pick--;
            end
        end
        return -1;
    endfunction

    function automatic int taken_block();
        int b;
        if (taken_map == '0) return -1;
        do begin
            b = $urandom_range(0, NUM_BLOCKS - 1);
        end while (!taken_map[b]);
        return b;
    endfunction

    task automatic test_basic_allocation();
        send_request(CMD_START, 0, 1'b0);
        send_request(CMD_DATA, 127, 1'b0);
        send_request(CMD_DATA, 5, 1'b1);
        send_request(CMD_START, 10, 1'b1);
        send_request(CMD_START, 50, 1'b0);
        send_request(CMD_DATA, 51, 1'b0);
        send_request(CMD_DATA, 51, 1'b1);
    endtask

    task automatic test_index_busy();
        send_request(CMD_START, 0, 1'b0);
        send_request(CMD_START, 127, 1'b1);
        send_request(CMD_START, 10, 1'b0);
    endtask

    task automatic test_no_open_file();
        send_request(CMD_DATA, 3, 1'b0);
        send_request(CMD_DATA, 126, 1'b1);
    endtask

    task automatic test_conflict_rejection();
        send_request(CMD_START, 20, 1'b0);
        send_request(CMD_DATA, 20, 1'b0);
        send_request(CMD_DATA, 30, 1'b1);
        send_request(CMD_START, 21, 1'b0);
        send_request(CMD_DATA, 0, 1'b1);
        send_request(CMD_START, 20, 1'b0);
        send_request(CMD_DATA, 30, 1'b1);
    endtask

    task automatic test_dropped_file();
        send_request(CMD_START, 40, 1'b0);
        send_request(CMD_DATA, 41, 1'b0);
        send_request(CMD_START, 42, 1'b0);
        send_request(CMD_DATA, 43, 1'b1);
        send_request(CMD_START, 40, 1'b1);
        send_request(CMD_DATA, 41, 1'b0);
        send_request(CMD_START, 41, 1'b1);
    endtask

    // A full pending list is accepted; one entry more is rejected.
    task automatic test_pending_list_limit();
        send_request(CMD_START, 60, 1'b0);
        for (int k = 0; k < NUM_BLOCKS + 1; k++) begin
            send_request(CMD_DATA, 61, k == NUM_BLOCKS);
        end
        send_request(CMD_START, 62, 1'b0);
        for (int k = 0; k < NUM_BLOCKS; k++) begin
            send_request(CMD_DATA, 63, k == NUM_BLOCKS - 1);
        end
    endtask

    task automatic test_output_backpressure();
        idle_en        = 1'b0;
        rx_hold_cycles = 300;
        for (int k = 0; k < 40; k++) begin
            send_request(1'($urandom_range(0, 1)), $urandom_range(0, NUM_BLOCKS - 1),
                         $urandom_range(0, 3) == 0);
        end
        idle_en = 1'b1;
    endtask

    task automatic test_random_files(input int n_items);
        int  sent;
        int  idx;
        int  n_data;
        int  bad_pos;
        int  cut_pos;
        int  blk;
        int  kind;
        bit  clean;
        sent = 0;
        while (sent < n_items) begin
            idle_en = ((sent / 200) % 3) != 2;
            kind    = $urandom_range(0, 19);
            if (kind == 0) begin
                send_request(CMD_DATA, $urandom_range(0, NUM_BLOCKS - 1),
                             1'($urandom_range(0, 1)));
                sent++;
            end else if (kind == 1) begin
                send_request(CMD_START, $urandom_range(0, NUM_BLOCKS - 1),
                             1'($urandom_range(0, 1)));
                sent++;
            end else begin
                idx = ($urandom_range(0, 9) < 8) ? free_block(-1) : -1;
                if (idx < 0) idx = $urandom_range(0, NUM_BLOCKS - 1);
                n_data  = ($urandom_range(0, 39) == 0) ? $urandom_range(7, 20)
                                                       : $urandom_range(0, 6);
                clean   = $urandom_range(0, 9) == 0;
                bad_pos = (n_data > 0) ? $urandom_range(0, n_data - 1) : 0;
                cut_pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_data) : n_data + 1;
                send_request(CMD_START, idx, n_data == 0);
                sent++;
                for (int k = 0; k < n_data && k < cut_pos; k++) begin
                    if (!clean && k == bad_pos) begin
                        blk = ($urandom_range(0, 1) == 0) ? taken_block() : idx;
                        if (blk < 0) blk = idx;
                    end else begin
                        blk = ($urandom_range(0, 5) == 0) ? -1 : free_block(idx);
                        if (blk < 0) blk = $urandom_range(0, NUM_BLOCKS - 1);
                    end
                    send_request(CMD_DATA, blk, k == n_data - 1);
                    sent++;
                end
            end
        end
        idle_en = 1'b1;
    endtask

    initial begin : result_checker
        int             rx_wait;
        t_alloc_outcome exp_res;
        rx_wait      = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t: unexpected result status=%0d index_block=%0d", $time,
                             res_if.status, res_if.index_block);
                    error_count++;
                end else begin
                    exp_res = outcome_q.pop_front();
                    if (res_if.status !== exp_res.status) begin
                        $display("%0t: status expected %0d, actual %0d", $time,
                                 exp_res.status, res_if.status);
                        error_count++;
                    end
                    if (res_if.index_block !== exp_res.index_block) begin
                        $display("%0t: index_block expected %0d, actual %0d", $time,
                                 exp_res.index_block, res_if.index_block);
                        error_count++;
                    end
                end
                rx_wait = idle_en ? $urandom_range(0, 9) : 0;
            end
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                rx_wait        = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (rx_wait > 0) begin
                res_if.ready <= 1'b0;
                rx_wait--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.command      = CMD_START;
        req_if.block_number = '0;
        req_if.last_item    = 1'b0;
        taken_map           = '0;
        open_index          = '0;
        file_open           = 1'b0;
        conflict_seen       = 1'b0;
        error_count         = 0;
        idle_en             = 1'b1;
        rx_hold_cycles      = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_basic_allocation();
        test_index_busy();
        test_no_open_file();
        test_conflict_rejection();
        test_dropped_file();
        test_pending_list_limit();
        test_output_backpressure();
        test_random_files(1300);

        req_if.valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
